// ===== src/tln_pkg.sv =====
// Shared types, byte codes and helpers for the text line normaliser.
// No dependencies; imported by every module of the block.
package tln_pkg;

    localparam int SPACE_DEPTH_DEF = 63;

    localparam logic [7:0] BYTE_TAB = 8'h09;
    localparam logic [7:0] BYTE_LF  = 8'h0A;
    localparam logic [7:0] BYTE_VT  = 8'h0B;
    localparam logic [7:0] BYTE_FF  = 8'h0C;
    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] BYTE_SP  = 8'h20;

    localparam logic [4:0] BLANK_RUN_MAX   = 5'd31;
    localparam logic [3:0] MAX_BLANK_RESET = 4'd1;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } t_out_item;

    typedef enum logic [1:0] {
        CLS_TEXT,
        CLS_WS,
        CLS_LF,
        CLS_EOI
    } t_cls;

    typedef enum logic [2:0] {
        OSEL_IN,
        OSEL_HELD,
        OSEL_CR,
        OSEL_LF,
        OSEL_BYTE
    } t_out_sel;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REPLAY,
        S_CR,
        S_LF,
        S_BYTE
    } t_state;

    typedef struct packed {
        logic     in_take;
        logic     out_load;
        t_out_sel out_sel;
        logic     out_last;
        logic     rep_next;
    } t_dp_cmd;

    typedef struct packed {
        t_cls cls;
        logic held_zero;
        logic rep_last;
        logic lf_emit;
        logic out_space;
    } t_dp_sts;

    function automatic t_cls classify(input t_in_item it);
        t_cls c;
        if (it.end_of_input) begin
            c = CLS_EOI;
        end else if (it.in_byte == BYTE_LF) begin
            c = CLS_LF;
        end else if (it.in_byte inside {BYTE_TAB, BYTE_VT, BYTE_FF, BYTE_CR, BYTE_SP}) begin
            c = CLS_WS;
        end else begin
            c = CLS_TEXT;
        end
        return c;
    endfunction

endpackage

// ===== src/text_line_normalizer_core.sv =====
// Text line normaliser: LF to CR LF with trailing whitespace trim and
// blank line limiting. Top level over tln_ctrl and tln_dp; uses tln_pkg.
//
// Input channel (i_in_valid/o_in_ready, i_in) takes one byte or an end
// marker per request. Output channel (o_out_valid/i_out_ready, o_out) gives
// bytes from a single output register; last_of_run marks the final byte of
// an input request. The config channel (i_cfg_valid/o_cfg_ready) is always
// ready and loads max_blank_lines; write it only while the block is idle.
// Output per input request:
//   whitespace or end marker: no output;
//   text byte with nothing held: straight into the output register if it has space;
//   text byte after n held whitespace bytes: the n held bytes replayed, then the byte;
//   LF: CR LF when it is emitted, nothing when the blank line is dropped.
// The replay of held whitespace reads the store one entry per cycle while the output is free.
// Reset clears the line state and sets max_blank_lines to 1; the store
// needs no clearing pass. If the receiver stalls, the output register
// holds its byte and the sequencer waits; o_in_ready is high only while
// no request is being worked on.
module text_line_normalizer_core import tln_pkg::*; #(
    parameter int SPACE_DEPTH = SPACE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [3:0] i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    tln_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    tln_dp #(
        .SPACE_DEPTH (SPACE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

// ===== src/tln_dp.sv =====
// Datapath of the text line normaliser: whitespace store, line state,
// config register and output register. Depends on tln_pkg.
module tln_dp import tln_pkg::*; #(
    parameter int SPACE_DEPTH = SPACE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in,
    input  logic      i_cfg_valid,
    input  logic [3:0] i_cfg_data,
    input  logic      i_out_ready,
    input  t_dp_cmd   i_cmd,
    output t_dp_sts   o_sts,
    output logic      o_out_valid,
    output t_out_item o_out
);

    localparam int CW = $clog2(SPACE_DEPTH + 1);
    localparam int AW = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1;

    logic [7:0]    r_held [SPACE_DEPTH];
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic [7:0]    r_rd;
    logic [7:0]    r_byte;
    logic          r_line_text, n_line_text;
    logic [4:0]    r_blank, n_blank;
    logic [3:0]    r_max;
    logic          r_out_valid;
    t_out_item     r_out, n_out;

    t_cls          cls;
    logic [4:0]    blank_inc;
    logic [4:0]    blank_lf;
    logic          not_full;
    logic          ws_write;

    always_comb begin
        cls       = classify(i_in);
        blank_inc = (r_blank == BLANK_RUN_MAX) ? r_blank : r_blank + 5'd1;
        blank_lf  = r_line_text ? 5'd0 : blank_inc;
        not_full  = r_count < CW'(SPACE_DEPTH);
        ws_write  = i_cmd.in_take && (cls == CLS_WS) && not_full;
    end

    always_comb begin
        o_sts.cls       = cls;
        o_sts.held_zero = (r_count == '0);
        o_sts.rep_last  = ((r_idx + CW'(1)) == r_count);
        o_sts.lf_emit   = (blank_lf <= {1'b0, r_max});
        o_sts.out_space = !r_out_valid || i_out_ready;
    end

    // replay index; read data always follows mem[r_idx]
    always_comb begin
        if (i_cmd.in_take) begin
            n_idx = '0;
        end else if (i_cmd.rep_next) begin
            n_idx = r_idx + CW'(1);
        end else begin
            n_idx = r_idx;
        end
    end

    always_comb begin
        n_count     = r_count;
        n_line_text = r_line_text;
        n_blank     = r_blank;
        if (i_cmd.in_take) begin
            case (cls)
                CLS_EOI: begin
                    n_count     = '0;
                    n_line_text = 1'b0;
                    n_blank     = '0;
                end
                CLS_LF: begin
                    n_count     = '0;
                    n_line_text = 1'b0;
                    n_blank     = blank_lf;
                end
                CLS_WS: begin
                    if (not_full) begin
                        n_count = r_count + CW'(1);
                    end
                end
                CLS_TEXT: begin
                    n_line_text = 1'b1;
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end else if (i_cmd.out_load && i_cmd.out_sel == OSEL_BYTE) begin
            n_count = '0;
        end
    end

    always_comb begin
        n_out.last_of_run = i_cmd.out_last;
        case (i_cmd.out_sel)
            OSEL_IN:   n_out.out_byte = i_in.in_byte;
            OSEL_HELD: n_out.out_byte = r_rd;
            OSEL_CR:   n_out.out_byte = BYTE_CR;
            OSEL_LF:   n_out.out_byte = BYTE_LF;
            OSEL_BYTE: n_out.out_byte = r_byte;
            default:   n_out.out_byte = r_byte;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idx       <= '0;
            r_line_text <= 1'b0;
            r_blank     <= '0;
            r_max       <= MAX_BLANK_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_line_text <= n_line_text;
            r_blank     <= n_blank;
            if (i_cfg_valid) begin
                r_max <= i_cfg_data;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ws_write) begin
            r_held[r_count[AW-1:0]] <= i_in.in_byte;
        end
        r_rd <= r_held[n_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_take) begin
            r_byte <= i_in.in_byte;
        end
        if (i_cmd.out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== src/tln_ctrl.sv =====
// Controller of the text line normaliser: sequences replay, text byte and CR LF output.
// Depends on tln_pkg; drives tln_dp through t_dp_cmd.
module tln_ctrl import tln_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_dp_sts i_sts,
    output logic    o_in_ready,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_in_ready     = (r_state == S_IDLE);
        o_cmd.in_take  = 1'b0;
        o_cmd.out_load = 1'b0;
        o_cmd.out_sel  = OSEL_IN;
        o_cmd.out_last = 1'b0;
        o_cmd.rep_next = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.in_take = 1'b1;
                    case (i_sts.cls)
                        CLS_LF: begin
                            if (i_sts.lf_emit) begin
                                if (i_sts.out_space) begin
                                    o_cmd.out_load = 1'b1;
                                    o_cmd.out_sel  = OSEL_CR;
                                    n_state        = S_LF;
                                end else begin
                                    n_state = S_CR;
                                end
                            end
                        end
                        CLS_TEXT: begin
                            if (!i_sts.held_zero) begin
                                n_state = S_REPLAY;
                            end else if (i_sts.out_space) begin
                                // nothing held: byte goes straight out
                                o_cmd.out_load = 1'b1;
                                o_cmd.out_sel  = OSEL_IN;
                                o_cmd.out_last = 1'b1;
                            end else begin
                                n_state = S_BYTE;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_REPLAY: begin
                if (i_sts.out_space) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OSEL_HELD;
                    if (i_sts.rep_last) begin
                        n_state = S_BYTE;
                    end else begin
                        o_cmd.rep_next = 1'b1;
                    end
                end
            end
            S_CR: begin
                if (i_sts.out_space) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OSEL_CR;
                    n_state        = S_LF;
                end
            end
            S_LF: begin
                if (i_sts.out_space) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OSEL_LF;
                    o_cmd.out_last = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_BYTE: begin
                if (i_sts.out_space) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OSEL_BYTE;
                    o_cmd.out_last = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/tln_chk.sv =====
// Port-level checks for text_line_normalizer_core, attached by bind.
// Depends on tln_pkg.
module tln_chk import tln_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input t_in_item   i_in,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input t_out_item  o_out
);

    logic in_acc;
    logic quiet_req;

    assign in_acc    = i_in_valid && o_in_ready;
    assign quiet_req = i_in.end_of_input
                    || i_in.in_byte == BYTE_TAB || i_in.in_byte == BYTE_VT
                    || i_in.in_byte == BYTE_FF  || i_in.in_byte == BYTE_CR
                    || i_in.in_byte == BYTE_SP;

    // whitespace and end markers produce no output, so the block stays ready
    a_quiet_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && quiet_req |=> o_in_ready)
        else $error("input not ready after whitespace or end request");

    // a CR is either replayed whitespace or the first of CR LF, never last
    a_cr_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.out_byte == BYTE_CR |-> !o_out.last_of_run)
        else $error("CR flagged as last of run");

    a_lf_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.out_byte == BYTE_LF |-> o_out.last_of_run)
        else $error("LF not flagged as last of run");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("stalled output changed");

endmodule

bind text_line_normalizer_core tln_chk u_chk (.*);

// ===== tb/text_line_normalizer_core_test.sv =====
// Testbench for text_line_normalizer_core: directed table, then random lines under
// several max_blank_lines settings, checked against a behavioural predictor.
// Depends on tln_pkg and the core RTL only.
module text_line_normalizer_core_test;
    import tln_pkg::*;

    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         IDLE_PCT       = 27;
    localparam int         OUT_HOLD       = 120;
    localparam int         DRAIN_CYCLES   = 20;
    localparam int         PHASE_ITEMS    = 25;
    localparam logic [1:0] PREDICTED      = 2'd3;

    localparam logic [7:0] SPACE_CODES [5] = '{BYTE_TAB, BYTE_VT, BYTE_FF, BYTE_CR, BYTE_SP};

    // one row of the directed table; n_typed = PREDICTED means use the predictor
    typedef struct packed {
        logic [7:0] in_byte;
        logic       eoi;
        logic [1:0] n_typed;
        logic [7:0] b0;
        logic [7:0] b1;
    } t_dir_row;

    localparam int DIR_ROWS = 25;
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        '{8'h41,   1'b0, 2'd1,      8'h41,   8'h00  },
        '{BYTE_LF, 1'b0, 2'd2,      BYTE_CR, BYTE_LF},
        '{BYTE_LF, 1'b0, 2'd2,      BYTE_CR, BYTE_LF},
        '{BYTE_LF, 1'b0, 2'd0,      8'h00,   8'h00  },
        '{BYTE_SP, 1'b0, 2'd0,      8'h00,   8'h00  },
        '{BYTE_TAB,1'b0, 2'd0,      8'h00,   8'h00  },
        '{BYTE_VT, 1'b0, 2'd0,      8'h00,   8'h00  },
        '{BYTE_FF, 1'b0, 2'd0,      8'h00,   8'h00  },
        '{BYTE_CR, 1'b0, 2'd0,      8'h00,   8'h00  },
        '{8'hFF,   1'b0, PREDICTED, 8'h00,   8'h00  },
        '{8'h00,   1'b0, 2'd1,      8'h00,   8'h00  },
        '{8'h80,   1'b0, 2'd1,      8'h80,   8'h00  },
        '{BYTE_SP, 1'b0, 2'd0,      8'h00,   8'h00  },
        '{BYTE_LF, 1'b0, 2'd2,      BYTE_CR, BYTE_LF},
        '{BYTE_TAB,1'b0, 2'd0,      8'h00,   8'h00  },
        '{BYTE_LF, 1'b0, PREDICTED, 8'h00,   8'h00  },
        '{BYTE_LF, 1'b0, 2'd0,      8'h00,   8'h00  },
        '{8'hFF,   1'b1, 2'd0,      8'h00,   8'h00  },
        '{BYTE_LF, 1'b0, PREDICTED, 8'h00,   8'h00  },
        '{8'h00,   1'b1, 2'd0,      8'h00,   8'h00  },
        '{8'h7A,   1'b0, 2'd1,      8'h7A,   8'h00  },
        '{8'h7F,   1'b0, 2'd1,      8'h7F,   8'h00  },
        '{8'h55,   1'b1, 2'd0,      8'h00,   8'h00  },
        '{8'hAA,   1'b0, 2'd1,      8'hAA,   8'h00  },
        '{8'h00,   1'b1, 2'd0,      8'h00,   8'h00  }
    };

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_in_item   i_in;
    logic       o_out_valid;
    logic       i_out_ready;
    t_out_item  o_out;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [3:0] i_cfg_data;

    text_line_normalizer_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // predictor state
    logic [7:0] held_ws [SPACE_DEPTH_DEF];
    int         held_n;
    logic       line_text;
    logic [4:0] blank_lines;
    logic [3:0] max_blank;

    t_out_item  step_out [$];
    t_out_item  due_bytes [$];
    int         items_sent;
    int         err_count;
    bit         no_idle;
    bit         hold_out;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic logic is_space(input logic [7:0] b);
        case (b)
            BYTE_TAB, BYTE_VT, BYTE_FF, BYTE_CR, BYTE_SP: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic void push_step(input logic [7:0] b);
        t_out_item r;
        r.out_byte    = b;
        r.last_of_run = 1'b0;
        step_out.push_back(r);
    endfunction

    // next state and output bytes for one request
    function automatic void normalise_byte(input t_in_item it);
        step_out.delete();
        if (it.end_of_input) begin
            held_n      = 0;
            line_text   = 1'b0;
            blank_lines = '0;
        end else if (it.in_byte == BYTE_LF) begin
            if (line_text) begin
                blank_lines = '0;
            end else if (blank_lines < BLANK_RUN_MAX) begin
                blank_lines = blank_lines + 5'd1;
            end
            if (blank_lines <= {1'b0, max_blank}) begin
                push_step(BYTE_CR);
                push_step(BYTE_LF);
            end
            held_n    = 0;
            line_text = 1'b0;
        end else if (is_space(it.in_byte)) begin
            if (held_n < SPACE_DEPTH_DEF) begin
                held_ws[held_n] = it.in_byte;
                held_n++;
            end
        end else begin
            for (int i = 0; i < held_n; i++) push_step(held_ws[i]);
            push_step(it.in_byte);
            held_n    = 0;
            line_text = 1'b1;
        end
        if (step_out.size() > 0) step_out[step_out.size() - 1].last_of_run = 1'b1;
    endfunction

    task automatic offer_request(input logic [7:0] b, input logic eoi,
                                 input logic [1:0] n_typed,
                                 input logic [7:0] b0, input logic [7:0] b1);
        t_in_item  it;
        t_out_item r;
        it.in_byte      = b;
        it.end_of_input = eoi;
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= it;
        do @(posedge i_clk); while (!o_in_ready);
        normalise_byte(it);
        if (n_typed == PREDICTED) begin
            foreach (step_out[k]) due_bytes.push_back(step_out[k]);
        end else begin
            for (int k = 0; k < n_typed; k++) begin
                r.out_byte    = (k == 0) ? b0 : b1;
                r.last_of_run = (k == n_typed - 1);
                due_bytes.push_back(r);
            end
        end
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        offer_request(b, 1'b0, PREDICTED, 8'h00, 8'h00);
    endtask

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == BYTE_LF || is_space(b));
        return b;
    endfunction

    function automatic logic [7:0] space_byte();
        return SPACE_CODES[$urandom_range(0, 4)];
    endfunction

    task automatic write_max_blank(input logic [3:0] v);
        while (due_bytes.size() != 0) @(posedge i_clk);
        // a whitespace request may still be in flight with nothing due
        repeat (8) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        max_blank = v;
    endtask

    // mostly well-formed lines; some noise, end markers and blank runs
    task automatic send_line();
        int r;
        int n;
        int k;
        r = $urandom_range(99);
        if (r < 12) begin
            n = $urandom_range(1, 4);
            for (k = 0; k < n; k++) send_byte(8'($urandom_range(0, 255)));
        end else if (r < 17) begin
            offer_request(8'($urandom_range(0, 255)), 1'b1, PREDICTED, 8'h00, 8'h00);
        end else if (r < 35) begin
            n = $urandom_range(1, 18);
            for (k = 0; k < n; k++) begin
                repeat ($urandom_range(0, 2)) send_byte(space_byte());
                send_byte(BYTE_LF);
            end
        end else begin
            n = $urandom_range(1, 6);
            for (k = 0; k < n; k++) begin
                if ($urandom_range(99) < 35) begin
                    repeat (($urandom_range(99) < 3) ? $urandom_range(60, 70)
                                                      : $urandom_range(1, 3))
                        send_byte(space_byte());
                end else begin
                    send_byte(text_byte());
                end
            end
            repeat ($urandom_range(0, 3)) send_byte(space_byte());
            send_byte(BYTE_LF);
        end
    endtask

    // receiver: random back-pressure, plus one long hold on request
    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_out) begin
                i_out_ready <= 1'b0;
                for (int c = 0; c < OUT_HOLD; c++) @(posedge i_clk);
                hold_out = 1'b0;
            end else begin
                i_out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_bytes.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected output byte %h last %b", o_out.out_byte,
                             o_out.last_of_run);
            end else begin
                want = due_bytes.pop_front();
                if (o_out.out_byte !== want.out_byte
                        || o_out.last_of_run !== want.last_of_run) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("mismatch: expected byte %h last %b, got byte %h last %b",
                                 want.out_byte, want.last_of_run,
                                 o_out.out_byte, o_out.last_of_run);
                end
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                    || (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin
        logic [3:0] phase_max [4];
        int         start;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in        <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        held_n      = 0;
        line_text   = 1'b0;
        blank_lines = '0;
        max_blank   = MAX_BLANK_RESET;
        items_sent  = 0;
        err_count   = 0;
        no_idle     = 1'b0;
        hold_out    = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIR_TABLE[i])
            offer_request(DIR_TABLE[i].in_byte, DIR_TABLE[i].eoi, DIR_TABLE[i].n_typed,
                          DIR_TABLE[i].b0, DIR_TABLE[i].b1);

        // overfill the whitespace store, then release it with one text byte
        repeat (66) send_byte(space_byte());
        send_byte(8'h5A);
        send_byte(BYTE_LF);
        i_in_valid <= 1'b0;

        phase_max = '{4'd0, 4'd15, 4'($urandom_range(2, 14)), 4'd1};
        foreach (phase_max[p]) begin
            write_max_blank(phase_max[p]);
            no_idle  = (p == 1);
            hold_out = (p == 2);
            start    = items_sent;
            while (items_sent - start < PHASE_ITEMS) send_line();
            i_in_valid <= 1'b0;
        end
        no_idle = 1'b0;

        while (due_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0 && due_bytes.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
